// ===== rtl/fadd_pkg.sv =====
`timescale 1ns / 1ps

package fadd_pkg;

    localparam logic [31:0] QNAN     = 32'h7FC0_0000;
    localparam logic [7:0]  EXP_MAX  = 8'hFF;

    // Operands after the magnitude swap, passed from unpacking to the adder.
    typedef struct packed {
        logic        special;
        logic [31:0] special_val;
        logic        sign_x;
        logic        eff_sub;
        logic        both_sign;
        logic [7:0]  ex;
        logic [26:0] mx;
        logic [26:0] my;
    } t_align;

    // Leading zero count over a 27-bit value, saturating at 27.
    function automatic logic [4:0] lzc27(input logic [26:0] v);
        logic [4:0] n;
        logic       found;
        n = 5'd27;
        found = 1'b0;
        for (int i = 26; i >= 0; i--) begin
            if (!found && v[i]) begin
                n = 5'(26 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

endpackage

// ===== rtl/fadd_align.sv =====
`timescale 1ns / 1ps

module fadd_align
    import fadd_pkg::*;
(
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output t_align      o_al
);

    logic [7:0]  ea, eb, ex, ey, d;
    logic [22:0] fa, fb;
    logic        a_nan, b_nan, a_inf, b_inf, swap;
    logic [31:0] x, y;
    logic [26:0] mx, my, sh, mask;

    always_comb begin
        ea = i_a[30:23];
        eb = i_b[30:23];
        fa = i_a[22:0];
        fb = i_b[22:0];
        a_nan = (ea == EXP_MAX) && (fa != 23'd0);
        b_nan = (eb == EXP_MAX) && (fb != 23'd0);
        a_inf = (ea == EXP_MAX);
        b_inf = (eb == EXP_MAX);

        // Special operands short-circuit the datapath.
        o_al.special = a_inf || b_inf;
        if (a_nan || b_nan || (a_inf && b_inf && (i_a[31] != i_b[31]))) begin
            o_al.special_val = QNAN;
        end else if (a_inf) begin
            o_al.special_val = i_a;
        end else begin
            o_al.special_val = i_b;
        end

        // Larger magnitude goes to x.
        swap = i_a[30:0] < i_b[30:0];
        x = swap ? i_b : i_a;
        y = swap ? i_a : i_b;
        ex = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
        ey = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
        mx = {(x[30:23] != 8'd0), x[22:0], 3'b000};
        my = {(y[30:23] != 8'd0), y[22:0], 3'b000};
        d  = ex - ey;

        // Align the smaller significand, folding lost bits into sticky.
        mask = ~(27'h7FF_FFFF << d[4:0]);
        if (d >= 8'd27) begin
            sh = {26'd0, (my != 27'd0)};
        end else begin
            sh = (my >> d[4:0]) | {26'd0, ((my & mask) != 27'd0)};
        end

        o_al.sign_x    = x[31];
        o_al.eff_sub   = i_a[31] != i_b[31];
        o_al.both_sign = i_a[31];
        o_al.ex        = ex;
        o_al.mx        = mx;
        o_al.my        = sh;
    end

endmodule

// ===== rtl/fadd_round.sv =====
`timescale 1ns / 1ps

module fadd_round
    import fadd_pkg::*;
(
    input  t_align      i_al,
    output logic [31:0] o_sum
);

    logic [27:0] m;
    logic [26:0] mn;
    logic [9:0]  e;
    logic [4:0]  lz, sft;
    logic [2:0]  low;
    logic [24:0] r;

    always_comb begin
        m = i_al.eff_sub ? ({1'b0, i_al.mx} - {1'b0, i_al.my})
                         : ({1'b0, i_al.mx} + {1'b0, i_al.my});
        e = {2'b00, i_al.ex};

        // Normalise: right by one on carry-out, else left limited by exponent.
        lz  = lzc27(m[26:0]);
        sft = lz;
        if (m[27]) begin
            mn = m[27:1] | {26'd0, m[0]};
            e  = e + 10'd1;
        end else begin
            if ({5'd0, lz} > (e - 10'd1)) begin
                sft = 5'(e - 10'd1);
            end
            mn = m[26:0] << sft;
            e  = e - {5'd0, sft};
        end

        // Round to nearest, ties to even.
        low = mn[2:0];
        r = {1'b0, mn[26:3]};
        if (low > 3'd4 || (low == 3'd4 && r[0])) begin
            r = r + 25'd1;
        end
        if (r[24]) begin
            r = r >> 1;
            e = e + 10'd1;
        end

        if (i_al.special) begin
            o_sum = i_al.special_val;
        end else if (m == 28'd0) begin
            o_sum = i_al.eff_sub ? 32'd0 : {i_al.both_sign, 31'd0};
        end else if (e >= 10'd255) begin
            o_sum = {i_al.sign_x, EXP_MAX, 23'd0};
        end else if (!r[23]) begin
            o_sum = {i_al.sign_x, 8'd0, r[22:0]};
        end else begin
            o_sum = {i_al.sign_x, e[7:0], r[22:0]};
        end
    end

endmodule

// ===== rtl/float32_adder.sv =====
`timescale 1ns / 1ps
// Binary32 adder, round to nearest even.
// A request passes an input register and then a result register before o_valid.
// Throughput: one request per cycle; busy is held low, the receiver cannot stall.
// The critical path is the align shift, 28-bit add and normalising shift.
// Synchronous active-low reset clears the valid pipeline; data are not reset.

module float32_adder
    import fadd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_a_bits,
    input  logic [31:0] i_b_bits,
    output logic        o_valid,
    output logic [31:0] o_sum_bits
);

    logic        r_v1, r_v2;
    logic [31:0] r_a, r_b, r_sum;
    logic [31:0] n_sum;
    t_align      al;

    assign busy = 1'b0;

    // Request valid pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= start;
            r_v2 <= r_v1;
        end
    end

    // Operand and result registers.
    always_ff @(posedge i_clk) begin
        if (start) begin
            r_a <= i_a_bits;
            r_b <= i_b_bits;
        end
        r_sum <= n_sum;
    end

    fadd_align u_align (.i_a(r_a), .i_b(r_b), .o_al(al));
    fadd_round u_round (.i_al(al), .o_sum(n_sum));

    assign o_valid    = r_v2;
    assign o_sum_bits = r_sum;

endmodule
